[hw/rtl/lrast_pkg.sv]
package lrast_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned ErrBits   = CoordBits + 3;
  localparam int unsigned ColorBits = 32;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [ColorBits-1:0] color_t;
  typedef logic signed [ErrBits-1:0] err_t;

  typedef enum logic {
    ActStart = 1'b0,
    ActNext  = 1'b1
  } action_e;

  typedef struct packed {
    action_e action;
    coord_t  x_start;
    coord_t  y_start;
    coord_t  x_end;
    coord_t  y_end;
    color_t  color;
  } in_word_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   pixel_valid;
    logic   last_pixel;
  } out_word_t;

endpackage

[hw/rtl/line_rasterizer_all_octants.sv]
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_ready_o   lrast_pkg::in_word_t
// out      output     out_valid_o / out_ready_i lrast_pkg::out_word_t
//
// One word in, one word out; the result is valid in the cycle after input accept.
// A new input word is taken every cycle while the result register is empty
// or being drained in the same cycle, so the rate is one pixel per clock.
// The stepper (one add and compare on the error term) sits between the line
// state registers and the result register. Reset clears all line state.
module line_rasterizer_all_octants (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lrast_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lrast_pkg::out_word_t out_word_o
);

  lrast_pkg::coord_t cur_x_q, cur_x_d;
  lrast_pkg::coord_t cur_y_q, cur_y_d;
  lrast_pkg::err_t   err_q, err_d;
  lrast_pkg::coord_t steps_q, steps_d;
  lrast_pkg::coord_t major_q, major_d;
  lrast_pkg::coord_t minor_q, minor_d;
  logic              x_neg_q, x_neg_d;
  logic              y_neg_q, y_neg_d;
  logic              x_major_q, x_major_d;
  logic              active_q, active_d;
  lrast_pkg::color_t color_q, color_d;

  logic                 out_valid_q, out_valid_d;
  lrast_pkg::out_word_t out_q, out_d;

  logic              in_fire;
  lrast_pkg::coord_t dx, dy, st_major, st_minor, steps_dec;
  logic              st_x_neg, st_y_neg, st_x_major, err_pos;
  lrast_pkg::err_t   min2, maj2;
  lrast_pkg::coord_t nx_x, nx_y;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // start setup
  assign st_x_neg   = in_word_i.x_end < in_word_i.x_start;
  assign st_y_neg   = in_word_i.y_end < in_word_i.y_start;
  assign dx         = st_x_neg ? in_word_i.x_start - in_word_i.x_end
                               : in_word_i.x_end - in_word_i.x_start;
  assign dy         = st_y_neg ? in_word_i.y_start - in_word_i.y_end
                               : in_word_i.y_end - in_word_i.y_start;
  assign st_x_major = dy <= dx;
  assign st_major   = st_x_major ? dx : dy;
  assign st_minor   = st_x_major ? dy : dx;

  // step terms from stored line
  assign min2      = $signed({2'b00, minor_q, 1'b0});
  assign maj2      = $signed({2'b00, major_q, 1'b0});
  assign err_pos   = !err_q[lrast_pkg::ErrBits-1] && (err_q != '0);
  assign steps_dec = steps_q - lrast_pkg::coord_t'(1);

  always_comb begin
    nx_x = cur_x_q;
    nx_y = cur_y_q;
    if (x_major_q || err_pos) begin
      nx_x = x_neg_q ? cur_x_q - lrast_pkg::coord_t'(1) : cur_x_q + lrast_pkg::coord_t'(1);
    end
    if (!x_major_q || err_pos) begin
      nx_y = y_neg_q ? cur_y_q - lrast_pkg::coord_t'(1) : cur_y_q + lrast_pkg::coord_t'(1);
    end
  end

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    err_d       = err_q;
    steps_d     = steps_q;
    major_d     = major_q;
    minor_d     = minor_q;
    x_neg_d     = x_neg_q;
    y_neg_d     = y_neg_q;
    x_major_d   = x_major_q;
    active_d    = active_q;
    color_d     = color_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      unique case (in_word_i.action)
        lrast_pkg::ActStart: begin
          cur_x_d   = in_word_i.x_start;
          cur_y_d   = in_word_i.y_start;
          x_neg_d   = st_x_neg;
          y_neg_d   = st_y_neg;
          x_major_d = st_x_major;
          major_d   = st_major;
          minor_d   = st_minor;
          steps_d   = st_major;
          err_d     = $signed({2'b00, st_minor, 1'b0}) - $signed({3'b000, st_major});
          color_d   = in_word_i.color;
          active_d  = st_major != '0;
          out_d.pixel_x     = in_word_i.x_start;
          out_d.pixel_y     = in_word_i.y_start;
          out_d.pixel_color = in_word_i.color;
          out_d.pixel_valid = 1'b1;
          out_d.last_pixel  = st_major == '0;
        end
        lrast_pkg::ActNext: begin
          if (!active_q || steps_q == '0) begin
            active_d = 1'b0;
            out_d    = '0;
          end else begin
            err_d    = err_pos ? err_q + min2 - maj2 : err_q + min2;
            cur_x_d  = nx_x;
            cur_y_d  = nx_y;
            steps_d  = steps_dec;
            active_d = steps_dec != '0;
            out_d.pixel_x     = nx_x;
            out_d.pixel_y     = nx_y;
            out_d.pixel_color = color_q;
            out_d.pixel_valid = 1'b1;
            out_d.last_pixel  = steps_dec == '0;
          end
        end
        default: begin
          out_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      err_q       <= '0;
      steps_q     <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      x_neg_q     <= 1'b0;
      y_neg_q     <= 1'b0;
      x_major_q   <= 1'b0;
      active_q    <= 1'b0;
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      err_q       <= err_d;
      steps_q     <= steps_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      x_neg_q     <= x_neg_d;
      y_neg_q     <= y_neg_d;
      x_major_q   <= x_major_d;
      active_q    <= active_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  a_active_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> steps_q != '0)
    else $error("active line with no steps left");

  a_idle_next_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_word_i.action == lrast_pkg::ActNext && !active_q
    |=> out_valid_q && !out_q.pixel_valid)
    else $error("next without active line gave a pixel");

  a_last_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.last_pixel |-> out_word_o.pixel_valid && !active_q)
    else $error("last pixel flagged on invalid result or line still active");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted word produced no result");

endmodule
